// File: hw/rtl/rsapbc_pkg.sv
// Package for the packed-byte modular exponentiation block.
// Holds the shared constants and the job record passed from front to back.
package rsapbc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 64;

  // Operation codes of the input stream
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Result kinds
  localparam logic KIND_CIPHER = 1'b0;
  localparam logic KIND_PLAIN  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_PUB_EXP  = 2'd0;
  localparam logic [1:0] REG_PRIV_EXP = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;

  // One exponentiation job handed from the front to the back
  typedef struct packed {
    logic              decrypt;
    logic [WORD_W-1:0] base;
  } job_t;

endpackage

// File: hw/rtl/rsapbc_front.sv
// Front end: accepts input items, packs plaintext bytes and issues jobs.
// Depends on rsapbc_pkg.
module rsapbc_front
  import rsapbc_pkg::*;
#(
  parameter int unsigned BYTES_PER_BLOCK = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_op,
  input  logic [BYTE_W-1:0] in_plain_byte,
  input  logic              in_end_of_text,
  input  logic [WORD_W-1:0] in_cipher_word,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);

  localparam int unsigned ACC_W = BYTES_PER_BLOCK * BYTE_W;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             jv_r, jv_nxt;
  job_t             job_r, job_nxt;
  logic [ACC_W-1:0] merged;
  logic             accept, close;

  // One-entry job queue; take an item when it is empty or draining
  assign in_tready = !jv_r || job_ready;
  assign accept    = in_tvalid && in_tready;
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    merged = acc_r;
    for (int i = 0; i < BYTES_PER_BLOCK; i++) begin
      if (cnt_r == 3'(i)) merged[i*BYTE_W +: BYTE_W] = in_plain_byte;
    end
    close = (cnt_r + 3'd1 >= 3'(BYTES_PER_BLOCK)) || in_end_of_text;
  end

  // Pack bytes and issue a job when a group closes or a word arrives
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    jv_nxt  = jv_r && !job_ready;
    job_nxt = job_r;
    if (accept) begin
      if (in_op == OP_ENCRYPT) begin
        if (close) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          jv_nxt  = 1'b1;
          job_nxt.decrypt = 1'b0;
          job_nxt.base    = WORD_W'(merged);
        end else begin
          acc_nxt = merged;
          cnt_nxt = cnt_r + 3'd1;
        end
      end else begin
        jv_nxt = 1'b1;
        job_nxt.decrypt = 1'b1;
        job_nxt.base    = in_cipher_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      jv_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      jv_r  <= jv_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

// File: hw/rtl/rsapbc_back.sv
// Back end: bit-serial modular exponentiation and result emission.
// Depends on rsapbc_pkg.
module rsapbc_back
  import rsapbc_pkg::*;
#(
  parameter int unsigned BYTES_PER_BLOCK = 6,
  parameter int unsigned MODULUS_WIDTH   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] pub_exp,
  input  logic [WORD_W-1:0] priv_exp,
  input  logic [WORD_W-1:0] modulus,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_kind,
  output logic [WORD_W-1:0] out_cipher,
  output logic [BYTE_W-1:0] out_plain,
  output logic              out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_STEP, S_MUL, S_EMIT
  } state_t;

  localparam logic [WORD_W-1:0] MOD_MASK = WORD_W'({MODULUS_WIDTH{1'b1}});

  state_t            state_r;
  logic [WORD_W-1:0] m_r, e_r, b_r, r_r, acc_r, a_r, mb_r;
  logic [6:0]        bit_r;
  logic              sq_r;     // current product is the squaring
  logic              dec_r;
  logic [2:0]        byte_r;
  logic              ov_r;     // output register holds an item

  // Add-mod helpers on 65-bit intermediates
  logic [WORD_W:0] dbl, dbl_s, add1, add1_s;
  logic [WORD_W-1:0] dbl_m, add_m;
  logic [WORD_W:0] red_sh, red_s;
  logic [WORD_W-1:0] red_m;
  logic [WORD_W-1:0] nb_byte;
  logic              more;
  logic              load;

  always_comb begin
    dbl   = {acc_r, 1'b0};
    dbl_s = dbl - {1'b0, m_r};
    dbl_m = dbl_s[WORD_W] ? dbl[WORD_W-1:0] : dbl_s[WORD_W-1:0];
    add1   = {1'b0, dbl_m} + {1'b0, a_r};
    add1_s = add1 - {1'b0, m_r};
    add_m  = add1_s[WORD_W] ? add1[WORD_W-1:0] : add1_s[WORD_W-1:0];
    red_sh = {acc_r, b_r[WORD_W-1]};
    red_s  = red_sh - {1'b0, m_r};
    red_m  = red_s[WORD_W] ? red_sh[WORD_W-1:0] : red_s[WORD_W-1:0];
    nb_byte = r_r >> (BYTE_W * 32'(byte_r));
    more    = (byte_r != 3'(BYTES_PER_BLOCK - 1)) &&
              ((nb_byte >> BYTE_W) & WORD_W'(8'hFF)) != '0;
    load    = (state_r == S_EMIT) && (!ov_r || out_tready) &&
              (!dec_r || nb_byte[BYTE_W-1:0] != '0);
  end

  assign job_ready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;

  // Exponentiation sequencer; reduction of the base is one subtract per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            m_r   <= modulus & MOD_MASK;
            e_r   <= job.decrypt ? priv_exp : pub_exp;
            dec_r <= job.decrypt;
            b_r   <= job.base;
            acc_r <= '0;
            bit_r <= 7'd0;
            state_r <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // restoring reduction of base mod m, one bit a cycle
          if (bit_r == 7'd0) begin
            acc_r <= '0;
            if (m_r < 64'd2) begin
              r_r     <= '0;
              byte_r  <= 3'd0;
              bit_r   <= 7'd0;
              state_r <= S_EMIT;
            end else begin
              bit_r <= 7'd64;
            end
          end else begin
            acc_r <= red_m;
            bit_r <= bit_r - 7'd1;
            if (bit_r == 7'd1) begin
              b_r     <= red_m;
              r_r     <= 64'd1;
              state_r <= S_STEP;
            end else begin
              b_r <= {b_r[WORD_W-2:0], 1'b0};
            end
          end
        end
        S_STEP: begin
          // choose next product: multiply if exponent bit set, else square; emit once the exponent is zero
          if (e_r == '0) begin
            r_r     <= (m_r == 64'd1) ? '0 : r_r;
            byte_r  <= 3'd0;
            state_r <= S_EMIT;
          end else begin
            sq_r  <= !e_r[0];
            a_r   <= e_r[0] ? r_r : b_r;
            mb_r  <= b_r;
            acc_r <= '0;
            bit_r <= 7'd64;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= mb_r[WORD_W-1] ? add_m : dbl_m;
          mb_r  <= {mb_r[WORD_W-2:0], 1'b0};
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd1) begin
            if (sq_r) begin
              b_r <= mb_r[WORD_W-1] ? add_m : dbl_m;
              e_r <= e_r >> 1;
              state_r <= S_STEP;
            end else begin
              r_r <= mb_r[WORD_W-1] ? add_m : dbl_m;
              e_r <= {e_r[WORD_W-1:1], 1'b0};
              state_r <= S_STEP;
            end
          end
        end
        S_EMIT: begin
          if (!ov_r || out_tready) begin
            if (!dec_r) begin
              out_kind   <= KIND_CIPHER;
              out_cipher <= r_r;
              out_plain  <= '0;
              out_last   <= 1'b1;
              state_r    <= S_IDLE;
            end else if (nb_byte[BYTE_W-1:0] == '0) begin
              state_r <= S_IDLE;
            end else begin
              out_kind   <= KIND_PLAIN;
              out_cipher <= '0;
              out_plain  <= nb_byte[BYTE_W-1:0];
              out_last   <= !more;
              byte_r     <= byte_r + 3'd1;
              if (!more) state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rsa_packed_block_cipher_top.sv
// Top level of the packed-byte modular exponentiation block.
// Depends on rsapbc_pkg, rsapbc_front and rsapbc_back.
//
// Encrypt items pack up to BYTES_PER_BLOCK bytes into a word and raise it to
// the public exponent; decrypt items raise a word to the private exponent and
// return its low bytes, up to BYTES_PER_BLOCK of them and up to the first zero
// byte. A group-closing or decrypt item, in the worst case with every exponent
// bit set, runs a start step, a bit-serial reduction of the base, then 127
// modular products (64 multiplies and 63 squarings), each a setup step and
// shift-and-add steps on one shared adder, then the emission of the results.
// Bytes that do not close a group are accepted without issuing a job.
module rsa_packed_block_cipher_top
  import rsapbc_pkg::*;
#(
  parameter int unsigned BYTES_PER_BLOCK = 6,
  parameter int unsigned MODULUS_WIDTH   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // op, plain_byte, end_of_text, cipher_word, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // cipher_out, plain_out
  output logic         out_tuser, // kind
  output logic         out_tlast  // last
);

  logic [WORD_W-1:0] pub_r, priv_r, mod_r;
  logic              job_valid, job_ready;
  job_t              job;
  logic [WORD_W-1:0] cip;
  logic [BYTE_W-1:0] pl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_r  <= 64'd1;
      priv_r <= 64'd1;
      mod_r  <= 64'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PUB_EXP:  pub_r  <= cfg_data;
        REG_PRIV_EXP: priv_r <= cfg_data;
        REG_MODULUS:  mod_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  rsapbc_front #(.BYTES_PER_BLOCK(BYTES_PER_BLOCK)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_op(in_tdata[0]), .in_plain_byte(in_tdata[8:1]),
    .in_end_of_text(in_tdata[9]), .in_cipher_word(in_tdata[73:10]),
    .job_valid, .job_ready, .job
  );

  rsapbc_back #(.BYTES_PER_BLOCK(BYTES_PER_BLOCK), .MODULUS_WIDTH(MODULUS_WIDTH)) u_back (
    .clk, .rst_n, .pub_exp(pub_r), .priv_exp(priv_r), .modulus(mod_r),
    .job_valid, .job_ready, .job,
    .out_tvalid, .out_tready, .out_kind(out_tuser),
    .out_cipher(cip), .out_plain(pl), .out_last(out_tlast)
  );

  assign out_tdata = {pl, cip};

endmodule

// File: test/rsa_packed_block_cipher_top_test.sv
// Self-checking bench for the packed-byte modular exponentiation block.
// Predicts cipher words and recovered bytes, drives random traffic with idling.
// Depends on rsapbc_pkg and rsa_packed_block_cipher_top.
`timescale 1ns / 100ps

module rsa_packed_block_cipher_top_test;
  import rsapbc_pkg::*;

  localparam int unsigned GROUP_BYTES = 6;
  localparam int unsigned IDLE_LIMIT  = 200000;
  localparam logic [1:0]  REG_UNKNOWN = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] cipher;
    logic [BYTE_W-1:0] plain;
    logic              last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // predictor copy of the registers and the packing state
  logic [63:0] pub_exp, priv_exp, mod_reg;
  logic [47:0] pack_word;
  int unsigned pack_fill;

  result_t expected_results[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;

  rsa_packed_block_cipher_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // (a * b) mod m at full precision
  function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
    logic [127:0] p;
    p = a * b;
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] ex,
                                            logic [63:0] m);
    logic [63:0] r, b;
    if (m < 2) return 64'd0;
    r = 64'd1;
    b = base % m;
    while (ex != 0) begin
      if (ex[0]) r = mod_product(r, b, m);
      b = mod_product(b, b, m);
      ex = ex >> 1;
    end
    return r;
  endfunction

  // work out the results one accepted item causes
  task automatic predict_item(logic op, logic [7:0] pb, logic eot, logic [63:0] cw);
    result_t r;
    logic [63:0] m;
    int n;
    if (op == OP_ENCRYPT) begin
      pack_word = pack_word | (48'(pb) << (8 * pack_fill));
      pack_fill = pack_fill + 1;
      if (pack_fill >= GROUP_BYTES || eot) begin
        r = '0;
        r.kind = KIND_CIPHER;
        r.cipher = mod_power({16'd0, pack_word}, pub_exp, mod_reg);
        r.last = 1'b1;
        expected_results = {expected_results, r};
        pack_word = '0;
        pack_fill = 0;
      end
    end else begin
      m = mod_power(cw, priv_exp, mod_reg);
      n = 0;
      for (int j = 0; j < GROUP_BYTES; j++) begin
        if (m[7:0] == 0) break;
        r = '0;
        r.kind = KIND_PLAIN;
        r.plain = m[7:0];
        expected_results = {expected_results, r};
        n++;
        m = m >> 8;
      end
      if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
    end
  endtask

  // offer one item, with random idling before it, and wait for acceptance;
  // valid stays high after acceptance so items can follow back to back
  task automatic send_item(logic op, logic [7:0] pb, logic eot, logic [63:0] cw);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, cw, eot, pb, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(op, pb, eot, cw);
  endtask

  // wait until all results are in, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  // write one register; the caller drops the write enable afterwards
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PUB_EXP:  pub_exp  = val;
      REG_PRIV_EXP: priv_exp = val;
      REG_MODULUS:  mod_reg  = val;
      default: ;
    endcase
  endtask

  task automatic set_key(logic [63:0] e, logic [63:0] d, logic [63:0] m);
    drain();
    write_reg(REG_PUB_EXP, e);
    write_reg(REG_PRIV_EXP, d);
    write_reg(REG_MODULUS, m);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // directed: reset key, extremes, both operations, special cases
  task automatic test_directed();
    send_item(OP_ENCRYPT, 8'hff, 1'b1, 64'd0);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'd3);
    set_key(64'd17, 64'd2753, 64'd3233);
    send_item(OP_ENCRYPT, 8'h41, 1'b1, 64'd0);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'd2790);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'hffff_ffff_ffff_ffff);
    set_key(64'd0, 64'd0, 64'hffff_ffff_ffff_ffff);
    send_item(OP_ENCRYPT, 8'h00, 1'b1, 64'd0);
    send_item(OP_DECRYPT, 8'hff, 1'b1, 64'd5);
    set_key(64'd1, 64'd1, 64'hffff_ffff_ffff_ffff);
    // full group, then a decrypt in the middle of a group
    for (int i = 0; i < GROUP_BYTES; i++)
      send_item(OP_ENCRYPT, 8'(8'h11 * (i + 1)), 1'b0, 64'd0);
    send_item(OP_ENCRYPT, 8'h01, 1'b0, 64'd0);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'h0000_4241_0000_0000);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'h0012_3456_789a_bcde);
    send_item(OP_ENCRYPT, 8'h80, 1'b1, 64'd0);
    set_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'd1);
    send_item(OP_ENCRYPT, 8'h7f, 1'b1, 64'd0);
    send_item(OP_DECRYPT, 8'h00, 1'b0, 64'd9);
    // unknown index must be ignored
    drain();
    write_reg(REG_UNKNOWN, 64'd0);
    cfg_we <= 1'b0;
    send_item(OP_ENCRYPT, 8'h55, 1'b1, 64'd0);
  endtask

  // random: mostly groups, some decrypts of fresh cipher words
  task automatic test_random(int unsigned count, logic [63:0] m_val);
    set_key(rand64(), rand64(), m_val);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_item(OP_DECRYPT, 8'($urandom), 1'($urandom), rand64());
      else
        send_item(OP_ENCRYPT, 8'($urandom), $urandom_range(4) == 0, rand64());
    end
  endtask

  // fill the block while the receiver holds off, then pause for a drain
  task automatic test_backpressure();
    hold_off_cycles = 40000;
    for (int i = 0; i < 6; i++)
      send_item(OP_DECRYPT, 8'd0, 1'b0, rand64());
    drain();
    for (int i = 0; i < 4; i++)
      send_item(OP_ENCRYPT, 8'($urandom), 1'b1, 64'd0);
  endtask

  // receiver ready: random stalls or a counted hold-off
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.cipher = out_tdata[63:0];
      got.plain = out_tdata[71:64];
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind %b/%b cipher %h/%h plain %h/%h last %b/%b",
                     want.kind, got.kind, want.cipher, got.cipher,
                     want.plain, got.plain, want.last, got.last);
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    errors = 0;
    checked = 0;
    idle_cycles = 0;
    hold_off_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pub_exp = 64'd1;
    priv_exp = 64'd1;
    mod_reg = 64'd2;
    pack_word = '0;
    pack_fill = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(28, 64'hffff_ffff_ffff_ffff);
    send_idle_pct = 51;
    test_random(28, rand64() | 64'h8000_0000_0000_0000);
    send_idle_pct = 0;
    recv_idle_pct = 51;
    test_random(28, {32'd0, $urandom} | 64'd2);
    send_idle_pct = 32;
    recv_idle_pct = 32;
    test_random(28, rand64() | 64'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    drain();

    $display("Covered both operations, group closing, special keys and stalls;");
    $display("%0d results checked.", checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: rsa_packed_block_cipher_top.f
hw/rtl/rsapbc_pkg.sv
hw/rtl/rsapbc_front.sv
hw/rtl/rsapbc_back.sv
hw/rtl/rsa_packed_block_cipher_top.sv
test/rsa_packed_block_cipher_top_test.sv
